// File: design/udrb_pkg.sv
package udrb_pkg;

    // Default ring size; each ring holds one byte less than this
    localparam int DEPTH_DEFAULT = 256;

    // Operation codes
    localparam logic [1:0] OP_LINE   = 2'd0;
    localparam logic [1:0] OP_PUT    = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;
    localparam logic [1:0] OP_INJECT = 2'd3;

    // Input word
    typedef struct packed {
        logic [1:0] op;
        logic       rx_ready;
        logic [7:0] data_byte;
        logic [3:0] err_flags;
        logic       tx_empty;
    } item_t;

    // Result word
    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic [7:0] read_byte;
        logic       accepted;
        logic       rx_dropped;
        logic [7:0] rx_avail;
        logic       tx_irq_enable;
        logic [3:0] error_seen;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

// File: design/udrb_ctrl.sv
module udrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output udrb_pkg::dp_cmd_t  cmd
);
    import udrb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   load;

    // A new word is taken whenever the datapath is not executing
    assign load = start && (state_reg != ST_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (load) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: state_next = load ? ST_EXEC : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy     = (state_reg == ST_EXEC);
    assign done     = (state_reg == ST_DONE);
    assign cmd.load = load;
    assign cmd.exec = (state_reg == ST_EXEC);

    // Every execute cycle is followed by exactly one result strobe
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute cycle not followed by result");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execute cycle");

    a_load_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start execution");

endmodule

// File: design/udrb_dp.sv
module udrb_dp #(
    parameter int DEPTH = udrb_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  udrb_pkg::dp_cmd_t  cmd,
    input  udrb_pkg::item_t    item,
    output udrb_pkg::result_t  result
);
    import udrb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Advance a ring pointer with wrap at DEPTH
    function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1))
            step_ptr = '0;
        else
            step_ptr = p + 1'b1;
    endfunction

    item_t         item_reg;
    logic [7:0]    rx_mem [DEPTH];
    logic [7:0]    tx_mem [DEPTH];
    logic [7:0]    rx_rd_reg;
    logic [7:0]    tx_rd_reg;

    logic [AW-1:0] rx_head_reg, rx_head_next;
    logic [AW-1:0] rx_tail_reg, rx_tail_next;
    logic [AW-1:0] tx_head_reg, tx_head_next;
    logic [AW-1:0] tx_tail_reg, tx_tail_next;
    logic [AW-1:0] rx_level_reg, rx_level_next;
    logic          tx_irq_reg, tx_irq_next;

    // Per-word result flags
    logic          line_valid_reg, line_valid_next;
    logic          fwd_reg, fwd_next;
    logic          get_ok_reg, get_ok_next;
    logic          accepted_reg, accepted_next;
    logic          dropped_reg, dropped_next;
    logic [3:0]    err_reg, err_next;
    logic [7:0]    fwd_byte_reg;

    logic          is_line, is_put, is_get, is_inj;
    logic          push_req, rx_full, push_ok;
    logic          put_ok, tx_busy_after, send;
    logic [AW-1:0] tx_head_after;
    logic          rx_we, rx_re, tx_we, tx_re;

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
    end

    // Decode and ring decisions for the word in execution
    always_comb
    begin
        is_line  = (item_reg.op == OP_LINE);
        is_put   = (item_reg.op == OP_PUT);
        is_get   = (item_reg.op == OP_GET);
        is_inj   = (item_reg.op == OP_INJECT);

        // receive side
        push_req = (is_line && item_reg.rx_ready) || is_inj;
        rx_full  = (step_ptr(rx_head_reg) == rx_tail_reg);
        push_ok  = push_req && !rx_full;

        // transmit side: queue first, then service
        put_ok        = is_put && (step_ptr(tx_head_reg) != tx_tail_reg);
        tx_head_after = put_ok ? step_ptr(tx_head_reg) : tx_head_reg;
        tx_busy_after = (tx_head_after != tx_tail_reg);
        send          = (is_line || is_put) && tx_busy_after && item_reg.tx_empty;

        rx_we = cmd.exec && push_ok;
        rx_re = cmd.exec && get_ok_next;
        tx_we = cmd.exec && put_ok;
        tx_re = cmd.exec && send;
    end

    always_comb
    begin
        get_ok_next      = is_get && (rx_head_reg != rx_tail_reg);
        line_valid_next  = send;
        // byte written this cycle to an empty ring goes straight to the line when tx_empty is set
        fwd_next         = put_ok && (tx_head_reg == tx_tail_reg);
        accepted_next    = put_ok || get_ok_next || (is_inj && push_ok);
        dropped_next     = is_line && item_reg.rx_ready && rx_full;
        err_next         = is_line ? item_reg.err_flags : 4'd0;

        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_level_next = rx_level_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_irq_next   = tx_irq_reg;
        if (cmd.exec)
        begin
            if (push_ok)
            begin
                rx_head_next  = step_ptr(rx_head_reg);
                rx_level_next = rx_level_reg + 1'b1;
            end
            if (get_ok_next)
            begin
                rx_tail_next  = step_ptr(rx_tail_reg);
                rx_level_next = rx_level_reg - 1'b1;
            end
            tx_head_next = tx_head_after;
            if (send)
                tx_tail_next = step_ptr(tx_tail_reg);
            if ((is_line || is_put) && tx_busy_after)
                tx_irq_next = (tx_head_after != (send ? step_ptr(tx_tail_reg) : tx_tail_reg));
        end
    end

    // Ring pointers, level and interrupt enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            rx_level_reg <= '0;
            tx_irq_reg   <= 1'b0;
        end
        else
        begin
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            rx_level_reg <= rx_level_next;
            tx_irq_reg   <= tx_irq_next;
        end
    end

    // Result flags, held until the next execution
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            line_valid_reg <= line_valid_next;
            fwd_reg        <= fwd_next;
            fwd_byte_reg   <= item_reg.data_byte;
            get_ok_reg     <= get_ok_next;
            accepted_reg   <= accepted_next;
            dropped_reg    <= dropped_next;
            err_reg        <= err_next;
        end
    end

    // Receive ring memory
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_head_reg] <= item_reg.data_byte;
        if (rx_re)
            rx_rd_reg <= rx_mem[rx_tail_reg];
    end

    // Transmit ring memory
    always_ff @(posedge clk)
    begin
        if (tx_we)
            tx_mem[tx_head_reg] <= item_reg.data_byte;
        if (tx_re)
            tx_rd_reg <= tx_mem[tx_tail_reg];
    end

    // Result word
    always_comb
    begin
        result.line_valid    = line_valid_reg;
        result.line_byte     = line_valid_reg ? (fwd_reg ? fwd_byte_reg : tx_rd_reg) : 8'd0;
        result.read_byte     = get_ok_reg ? rx_rd_reg : 8'd0;
        result.accepted      = accepted_reg;
        result.rx_dropped    = dropped_reg;
        result.rx_avail      = 8'(rx_level_reg);
        result.tx_irq_enable = tx_irq_reg;
        result.error_seen    = err_reg;
    end

    // Occupancy derived from the pointers, for checking the level counter
    logic [AW:0] rx_occ;
    always_comb
    begin
        if (rx_head_reg >= rx_tail_reg)
            rx_occ = {1'b0, rx_head_reg} - {1'b0, rx_tail_reg};
        else
            rx_occ = {1'b0, rx_head_reg} + (AW+1)'(DEPTH) - {1'b0, rx_tail_reg};
    end

    a_level_matches: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rx_level_reg} == rx_occ)
        else $error("receive level out of step with pointers");

    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> ($stable(rx_head_reg) && $stable(tx_head_reg) && $stable(tx_irq_reg)))
        else $error("ring state moved outside execution");

    a_one_rx_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_we && rx_re))
        else $error("receive ring pushed and popped in one word");

endmodule

// File: design/uart_dual_ring_buffer_unit.sv
// UART receive/transmit ring buffer. Pulse start with a word while busy is low;
// the block executes it in the following cycle (one ring memory write and/or one
// registered ring read plus pointer updates) and shows the result for exactly
// one cycle with done high, in the state after the execute state. There is no
// backpressure on results: sample them whenever done is high. A new word can be
// accepted in the same cycle a result is shown, but not while a word is
// executing. Each ring has DEPTH entries and holds at most DEPTH-1 bytes;
// rx_avail gives the low eight bits of the receive level.
module uart_dual_ring_buffer_unit #(
    parameter int DEPTH = udrb_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  udrb_pkg::item_t    item,
    output logic               done,
    output udrb_pkg::result_t  result
);
    import udrb_pkg::*;

    dp_cmd_t cmd;

    // Sequencer
    udrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Rings and pointers
    udrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule
